// ----- src/skrt_pkg.sv -----
package skrt_pkg;

  localparam int KEY_W   = 32;
  localparam int SCORE_W = 7;
  localparam int TOTAL_W = 9;
  localparam int POS_W   = 6;
  localparam int COUNT_W = 7;

  typedef enum logic [1:0] {
    KIND_INSERT = 2'd0,
    KIND_DELETE = 2'd1,
    KIND_LOOKUP = 2'd2,
    KIND_MODIFY = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ST_DONE      = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_DUPLICATE = 2'd2,
    ST_FULL      = 2'd3
  } status_t;

  typedef struct packed {
    logic [SCORE_W-1:0] a;
    logic [SCORE_W-1:0] b;
    logic [SCORE_W-1:0] c;
  } scores_t;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    scores_t          sc;
  } rec_t;

endpackage

// ----- src/skrt_req_if.sv -----
interface skrt_req_if;
  import skrt_pkg::*;

  logic                 valid;
  logic                 ready;
  kind_t                kind;
  logic [KEY_W-1:0]     key;
  logic [SCORE_W-1:0]   score_a;
  logic [SCORE_W-1:0]   score_b;
  logic [SCORE_W-1:0]   score_c;

  modport source (output valid, kind, key, score_a, score_b, score_c, input ready);
  modport sink   (input valid, kind, key, score_a, score_b, score_c, output ready);
endinterface

// ----- src/skrt_rsp_if.sv -----
interface skrt_rsp_if;
  import skrt_pkg::*;

  logic                 valid;
  logic                 ready;
  status_t              status;
  logic [POS_W-1:0]     position;
  logic [COUNT_W-1:0]   entry_count;
  logic [SCORE_W-1:0]   out_score_a;
  logic [SCORE_W-1:0]   out_score_b;
  logic [SCORE_W-1:0]   out_score_c;
  logic [TOTAL_W-1:0]   score_total;

  modport source (output valid, status, position, entry_count, out_score_a, out_score_b,
                  out_score_c, score_total, input ready);
  modport sink   (input valid, status, position, entry_count, out_score_a, out_score_b,
                  out_score_c, score_total, output ready);
endinterface

// ----- src/sorted_key_record_table_top.sv -----
// Channel   Dir  Handshake      Payload
// in_ch     in   valid/ready    kind, key, score_a, score_b, score_c
// out_ch    out  valid/ready    status, position, entry_count, out_score_a..c, score_total
//
// One request at a time. A request scans the table from entry 0 at one memory read per
// cycle and stops at the first key not below its own, or at position count when there is
// none, then moves entries one per cycle from that position through the single read and
// write port (count - position moves for insert, count - 1 - position for delete), then
// registers its result; the next request is taken in the cycle after that.
// Reset (rst_n low, synchronous) empties the table; memory contents are not cleared.
// A result waits in the output register; the next request is taken meanwhile and
// holds in its last cycle until that register frees up.
module sorted_key_record_table_top #(
  parameter int TABLE_DEPTH = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  skrt_req_if.sink    in_ch,
  skrt_rsp_if.source  out_ch
);
  import skrt_pkg::*;

  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);
  localparam logic [CW-1:0] ONE_C   = CW'(1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_DECIDE,
    S_MOVE,
    S_DONE
  } state_t;

  rec_t            mem [TABLE_DEPTH];
  rec_t            rd_data_r;
  logic            rd_en;
  logic [AW-1:0]   rd_addr;
  logic            wr_en;
  logic [AW-1:0]   wr_addr;
  rec_t            wr_data;

  state_t          state_r;
  kind_t           kind_r;
  logic [KEY_W-1:0] key_r;
  scores_t         new_sc_r;
  logic [CW-1:0]   count_r;
  logic [CW-1:0]   scan_idx_r;
  logic            cmp_vld_r;
  logic [AW-1:0]   cmp_idx_r;
  logic            found_r;
  logic [CW-1:0]   pos_r;
  scores_t         hit_sc_r;
  logic [CW-1:0]   mv_left_r;
  logic [AW-1:0]   mv_src_r;
  logic            mv_pend_r;
  logic [AW-1:0]   mv_dst_r;
  status_t         res_status_r;
  logic [CW-1:0]   res_pos_r;
  scores_t         res_sc_r;

  logic            out_valid_r;
  status_t         out_status_r;
  logic [POS_W-1:0] out_pos_r;
  logic [COUNT_W-1:0] out_count_r;
  scores_t         out_sc_r;
  logic [TOTAL_W-1:0] out_total_r;

  logic            scan_issue;
  logic            mv_issue;
  logic            key_eq;
  logic            key_gt;
  logic [CW-1:0]   count_m1;
  logic [CW-1:0]   pos_p1;

  assign scan_issue = (state_r == S_SCAN) && (scan_idx_r < count_r);
  assign mv_issue   = (state_r == S_MOVE) && (mv_left_r != '0);
  assign key_eq     = (rd_data_r.key == key_r);
  assign key_gt     = (rd_data_r.key > key_r);
  assign count_m1   = count_r - ONE_C;
  assign pos_p1     = pos_r + ONE_C;

  always_comb begin
    rd_en   = 1'b0;
    rd_addr = '0;
    wr_en   = 1'b0;
    wr_addr = '0;
    wr_data = rd_data_r;
    if (scan_issue) begin
      rd_en   = 1'b1;
      rd_addr = scan_idx_r[AW-1:0];
    end
    if (mv_issue) begin
      rd_en   = 1'b1;
      rd_addr = mv_src_r;
    end
    if (state_r == S_DECIDE && kind_r == KIND_MODIFY && found_r) begin
      wr_en   = 1'b1;
      wr_addr = pos_r[AW-1:0];
      wr_data = '{key: key_r, sc: new_sc_r};
    end
    if (state_r == S_MOVE) begin
      if (mv_pend_r) begin
        wr_en   = 1'b1;
        wr_addr = mv_dst_r;
        wr_data = rd_data_r;
      end else if (!mv_issue && kind_r == KIND_INSERT) begin
        wr_en   = 1'b1;
        wr_addr = pos_r[AW-1:0];
        wr_data = '{key: key_r, sc: new_sc_r};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      cmp_vld_r   <= 1'b0;
      mv_pend_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_ch.valid) begin
            kind_r     <= in_ch.kind;
            key_r      <= in_ch.key;
            new_sc_r   <= '{a: in_ch.score_a, b: in_ch.score_b, c: in_ch.score_c};
            scan_idx_r <= '0;
            cmp_vld_r  <= 1'b0;
            state_r    <= S_SCAN;
          end
        end
        S_SCAN: begin
          cmp_vld_r <= scan_issue;
          cmp_idx_r <= scan_idx_r[AW-1:0];
          if (scan_issue) begin
            scan_idx_r <= scan_idx_r + ONE_C;
          end
          if (cmp_vld_r && (key_eq || key_gt)) begin
            found_r  <= key_eq;
            pos_r    <= CW'(cmp_idx_r);
            hit_sc_r <= rd_data_r.sc;
            state_r  <= S_DECIDE;
          end else if (!cmp_vld_r && !scan_issue) begin
            found_r <= 1'b0;
            pos_r   <= count_r;
            state_r <= S_DECIDE;
          end
        end
        S_DECIDE: begin
          res_pos_r <= pos_r;
          res_sc_r  <= hit_sc_r;
          mv_pend_r <= 1'b0;
          state_r   <= S_DONE;
          unique case (kind_r)
            KIND_INSERT: begin
              priority if (found_r) begin
                res_status_r <= ST_DUPLICATE;
              end else if (count_r == DEPTH_C) begin
                res_status_r <= ST_FULL;
                res_pos_r    <= '0;
                res_sc_r     <= '0;
              end else begin
                res_status_r <= ST_DONE;
                res_sc_r     <= new_sc_r;
                mv_left_r    <= count_r - pos_r;
                mv_src_r     <= count_m1[AW-1:0];
                state_r      <= S_MOVE;
              end
            end
            KIND_DELETE: begin
              if (found_r) begin
                res_status_r <= ST_DONE;
                mv_left_r    <= count_m1 - pos_r;
                mv_src_r     <= pos_p1[AW-1:0];
                state_r      <= S_MOVE;
              end else begin
                res_status_r <= ST_NOT_FOUND;
                res_pos_r    <= '0;
                res_sc_r     <= '0;
              end
            end
            KIND_LOOKUP, KIND_MODIFY: begin
              if (found_r) begin
                res_status_r <= ST_DONE;
                if (kind_r == KIND_MODIFY) begin
                  res_sc_r <= new_sc_r;
                end
              end else begin
                res_status_r <= ST_NOT_FOUND;
                res_pos_r    <= '0;
                res_sc_r     <= '0;
              end
            end
          endcase
        end
        S_MOVE: begin
          mv_pend_r <= mv_issue;
          if (mv_issue) begin
            mv_left_r <= mv_left_r - ONE_C;
            if (kind_r == KIND_INSERT) begin
              mv_src_r <= mv_src_r - 1'b1;
              mv_dst_r <= mv_src_r + 1'b1;
            end else begin
              mv_src_r <= mv_src_r + 1'b1;
              mv_dst_r <= mv_src_r - 1'b1;
            end
          end else if (!mv_pend_r) begin
            count_r <= (kind_r == KIND_INSERT) ? count_r + ONE_C : count_m1;
            state_r <= S_DONE;
          end
        end
        S_DONE: begin
          if (!out_valid_r || out_ch.ready) begin
            out_valid_r  <= 1'b1;
            out_status_r <= res_status_r;
            out_pos_r    <= POS_W'(res_pos_r);
            out_count_r  <= COUNT_W'(count_r);
            out_sc_r     <= res_sc_r;
            out_total_r  <= TOTAL_W'(res_sc_r.a) + TOTAL_W'(res_sc_r.b)
                            + TOTAL_W'(res_sc_r.c);
            state_r      <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign in_ch.ready        = (state_r == S_IDLE);
  assign out_ch.valid       = out_valid_r;
  assign out_ch.status      = out_status_r;
  assign out_ch.position    = out_pos_r;
  assign out_ch.entry_count = out_count_r;
  assign out_ch.out_score_a = out_sc_r.a;
  assign out_ch.out_score_b = out_sc_r.b;
  assign out_ch.out_score_c = out_sc_r.c;
  assign out_ch.score_total = out_total_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= DEPTH_C)
    else $error("entry count beyond table depth");

  a_write_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> ({1'b0, wr_addr} <= {1'b0, count_r}))
    else $error("memory write beyond the used entries");

  a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_DONE))
    else $error("result raised outside the done state");

  a_full_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status_r == ST_FULL) |-> (out_count_r == COUNT_W'(DEPTH_C)))
    else $error("table full reported with free entries");

endmodule
